// ----- rtl/vbap_pkg.sv -----
// Shared types, codes and widths of the VBAP 2D panner.
package vbap_pkg;

  localparam int CFG_W   = 13;
  localparam int DIV_W   = 62;
  localparam int DVS_W   = 32;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int OP_W    = 5;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DIR    = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic CFG_SPK_COUNT = 1'b0;
  localparam logic CFG_BLOCK_LEN = 1'b1;

  localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
  localparam logic [OP_W-1:0] OP_SC_RD     = 5'd1;
  localparam logic [OP_W-1:0] OP_SC_MUL    = 5'd2;
  localparam logic [OP_W-1:0] OP_SC_CMP    = 5'd3;
  localparam logic [OP_W-1:0] OP_P1_RD     = 5'd4;
  localparam logic [OP_W-1:0] OP_P2_RD     = 5'd5;
  localparam logic [OP_W-1:0] OP_P_CAP     = 5'd6;
  localparam logic [OP_W-1:0] OP_DET_MUL   = 5'd7;
  localparam logic [OP_W-1:0] OP_A1_MUL    = 5'd8;
  localparam logic [OP_W-1:0] OP_A2_MUL    = 5'd9;
  localparam logic [OP_W-1:0] OP_A2_SUB    = 5'd10;
  localparam logic [OP_W-1:0] OP_CHK       = 5'd11;
  localparam logic [OP_W-1:0] OP_NORM      = 5'd12;
  localparam logic [OP_W-1:0] OP_SQ1       = 5'd13;
  localparam logic [OP_W-1:0] OP_SQ2       = 5'd14;
  localparam logic [OP_W-1:0] OP_SQRT_GO   = 5'd15;
  localparam logic [OP_W-1:0] OP_SQRT_WAIT = 5'd16;
  localparam logic [OP_W-1:0] OP_G1_GO     = 5'd17;
  localparam logic [OP_W-1:0] OP_G1_WAIT   = 5'd18;
  localparam logic [OP_W-1:0] OP_G2_GO     = 5'd19;
  localparam logic [OP_W-1:0] OP_G2_WAIT   = 5'd20;
  localparam logic [OP_W-1:0] OP_ST_RD     = 5'd21;
  localparam logic [OP_W-1:0] OP_ST_GO     = 5'd22;
  localparam logic [OP_W-1:0] OP_ST_WAIT   = 5'd23;
  localparam logic [OP_W-1:0] OP_SM_RD     = 5'd24;
  localparam logic [OP_W-1:0] OP_SM_UPD    = 5'd25;
  localparam logic [OP_W-1:0] OP_SM_MUL    = 5'd26;
  localparam logic [OP_W-1:0] OP_SM_EMIT   = 5'd27;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         speaker_index;
    logic signed [15:0] speaker_x;
    logic signed [15:0] speaker_y;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic signed [23:0] sample_in;
  } vbap_in_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [23:0] sample_out;
    logic               last;
  } vbap_out_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
  } vbap_cmd_t;

  typedef struct packed {
    logic k_last;
    logic k_emit;
    logic k_end;
    logic big;
    logic degen;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } vbap_stat_t;

endpackage

// ----- rtl/vbap_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module vbap_div
  import vbap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/vbap_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module vbap_sqrt
  import vbap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   n_r, n_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+1:0] rem2;
  logic [ROOT_W+1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem2     = {rem_r[ROOT_W-1:0], n_r[SQ_W-1:SQ_W-2]};
    trial    = {root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      n_nxt = {n_r[SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/vbap_ctrl.sv -----
// Sequencing state machine of the panner.
module vbap_ctrl
  import vbap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  input  vbap_stat_t stat,
  output vbap_cmd_t  cmd
);

  logic [OP_W-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_DIR:    state_nxt = OP_SC_RD;
            FUNC_SAMPLE: state_nxt = OP_SM_RD;
            default:     state_nxt = OP_IDLE;
          endcase
        end
      end
      OP_SC_RD:     state_nxt = OP_SC_MUL;
      OP_SC_MUL:    state_nxt = OP_SC_CMP;
      OP_SC_CMP:    state_nxt = stat.k_last ? OP_P1_RD : OP_SC_RD;
      OP_P1_RD:     state_nxt = OP_P2_RD;
      OP_P2_RD:     state_nxt = OP_P_CAP;
      OP_P_CAP:     state_nxt = OP_DET_MUL;
      OP_DET_MUL:   state_nxt = OP_A1_MUL;
      OP_A1_MUL:    state_nxt = OP_A2_MUL;
      OP_A2_MUL:    state_nxt = OP_A2_SUB;
      OP_A2_SUB:    state_nxt = OP_CHK;
      OP_CHK:       state_nxt = stat.degen ? OP_ST_RD : OP_NORM;
      OP_NORM:      state_nxt = stat.big ? OP_SQ1 : OP_NORM;
      OP_SQ1:       state_nxt = OP_SQ2;
      OP_SQ2:       state_nxt = OP_SQRT_GO;
      OP_SQRT_GO:   state_nxt = OP_SQRT_WAIT;
      OP_SQRT_WAIT: state_nxt = stat.sqrt_done ? OP_G1_GO : OP_SQRT_WAIT;
      OP_G1_GO:     state_nxt = OP_G1_WAIT;
      OP_G1_WAIT:   state_nxt = stat.div_done ? OP_G2_GO : OP_G1_WAIT;
      OP_G2_GO:     state_nxt = OP_G2_WAIT;
      OP_G2_WAIT:   state_nxt = stat.div_done ? OP_ST_RD : OP_G2_WAIT;
      OP_ST_RD:     state_nxt = OP_ST_GO;
      OP_ST_GO:     state_nxt = OP_ST_WAIT;
      OP_ST_WAIT: begin
        if (stat.div_done) state_nxt = stat.k_end ? OP_IDLE : OP_ST_RD;
      end
      OP_SM_RD:     state_nxt = OP_SM_UPD;
      OP_SM_UPD:    state_nxt = OP_SM_MUL;
      OP_SM_MUL:    state_nxt = OP_SM_EMIT;
      OP_SM_EMIT: begin
        if (!stat.k_emit || stat.out_free) state_nxt = stat.k_end ? OP_IDLE : OP_SM_RD;
      end
      default:      state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == OP_IDLE);
  assign cmd.op     = state_r;
  assign cmd.accept = in_ready && in_valid;

endmodule

// ----- rtl/vbap_dp.sv -----
// Datapath: speaker table, gain ramps, solver arithmetic and output register.
module vbap_dp
  import vbap_pkg::*;
#(
  parameter int MAX_SPEAKERS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  vbap_in_t         in_data,
  output vbap_out_t        out_data,
  output logic             out_valid,
  input  logic             out_ready,
  input  vbap_cmd_t        cmd,
  output vbap_stat_t       stat
);

  localparam int IW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
  localparam logic signed [31:0] G_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] G_MIN = 32'sh80000000;

  logic [4:0]       sc_r;
  logic [CFG_W-1:0] bl_r;
  logic [7:0]       n_eff;
  logic [CFG_W-1:0] len;
  vbap_in_t         in_r;
  logic [IW-1:0]    k_r;

  logic signed [15:0] tx_mem [MAX_SPEAKERS];
  logic signed [15:0] ty_mem [MAX_SPEAKERS];
  logic signed [15:0] tx_rd_r, ty_rd_r;
  logic [IW-1:0]      tab_addr;
  logic               tab_we;

  logic signed [31:0] cur_mem  [MAX_SPEAKERS];
  logic signed [31:0] step_mem [MAX_SPEAKERS];
  logic [MAX_SPEAKERS-1:0] cur_vld_r, step_vld_r;
  logic signed [31:0] cur_rd_r, step_rd_r;
  logic               cur_v_r, step_v_r;
  logic signed [31:0] cur_q, step_q;
  logic               cur_we, step_we;
  logic signed [31:0] cur_wd, step_wd;

  logic signed [15:0] ma0, ma1, mb0, mb1;
  logic signed [31:0] pa_r, pb_r;
  logic signed [32:0] dot, diff_ab, abs_ab;

  logic signed [32:0] best1_r, best2_r;
  logic               b2_vld_r;
  logic [IW-1:0]      s1_r, s2_r;
  logic signed [15:0] x1_r, y1_r, x2_r, y2_r;
  logic               detn_r, detnz_r, a1n_r, a2n_r;
  logic [30:0]        m1_r, m2_r;
  logic [61:0]        sq1_r, sq2_r;
  logic [ROOT_W-1:0]  r_r;
  logic signed [31:0] t1_r, t2_r;

  logic               div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;
  logic [ROOT_W-1:0]  sqrt_root;
  logic signed [31:0] gs;
  logic signed [31:0] tgt;
  logic signed [32:0] sdiff;
  logic [32:0]        smag;
  logic               sneg_r;
  logic [32:0]        qmag;
  logic signed [32:0] csum;
  logic signed [31:0] cnew_r;
  logic signed [55:0] prod_r;
  logic signed [56:0] rnd, shv;
  logic signed [23:0] smp_sat;

  logic               out_valid_r;
  vbap_out_t          out_r;
  logic               out_free, emit_go, advance;

  always_comb begin
    if (sc_r < 5'd2) n_eff = 8'd2;
    else if (int'(sc_r) > MAX_SPEAKERS) n_eff = 8'(MAX_SPEAKERS);
    else n_eff = 8'(sc_r);
  end
  assign len = (bl_r == '0) ? CFG_W'(1) : bl_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= 5'd2;
      bl_r <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPK_COUNT: sc_r <= cfg_wdata[4:0];
        CFG_BLOCK_LEN: bl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign stat.k_last = (int'(k_r) + 1 == int'(n_eff));
  assign stat.k_emit = (int'(k_r) < int'(n_eff));
  assign stat.k_end  = (int'(k_r) == MAX_SPEAKERS - 1);
  assign stat.big    = m1_r[30] | m2_r[30];
  assign stat.degen  = !detnz_r || (m1_r == '0 && m2_r == '0);
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.out_free  = out_free;

  // speaker table
  assign tab_we = cmd.accept && in_data.func == FUNC_LOAD &&
                  int'(in_data.speaker_index) < MAX_SPEAKERS;
  always_comb begin
    case (cmd.op)
      OP_P1_RD: tab_addr = s1_r;
      OP_P2_RD: tab_addr = s2_r;
      default:  tab_addr = k_r;
    endcase
  end
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tx_mem[IW'(in_data.speaker_index)] <= in_data.speaker_x;
      ty_mem[IW'(in_data.speaker_index)] <= in_data.speaker_y;
    end
    tx_rd_r <= tx_mem[tab_addr];
    ty_rd_r <= ty_mem[tab_addr];
  end

  // gain and step memories, valid bits give the zero reset
  assign cur_q  = cur_v_r ? cur_rd_r : '0;
  assign step_q = step_v_r ? step_rd_r : '0;
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[k_r] <= cur_wd;
    if (step_we) step_mem[k_r] <= step_wd;
    cur_rd_r  <= cur_mem[k_r];
    step_rd_r <= step_mem[k_r];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= '0;
      step_vld_r <= '0;
      cur_v_r    <= 1'b0;
      step_v_r   <= 1'b0;
    end else begin
      if (cur_we) cur_vld_r[k_r] <= 1'b1;
      if (step_we) step_vld_r[k_r] <= 1'b1;
      cur_v_r  <= cur_vld_r[k_r];
      step_v_r <= step_vld_r[k_r];
    end
  end

  // shared multiplier pair
  always_comb begin
    ma0 = in_r.source_x; ma1 = tx_rd_r;
    mb0 = in_r.source_y; mb1 = ty_rd_r;
    case (cmd.op)
      OP_DET_MUL: begin ma0 = x1_r; ma1 = y2_r; mb0 = x2_r; mb1 = y1_r; end
      OP_A1_MUL: begin ma0 = in_r.source_x; ma1 = y2_r; mb0 = in_r.source_y; mb1 = x2_r; end
      OP_A2_MUL: begin ma0 = in_r.source_y; ma1 = x1_r; mb0 = in_r.source_x; mb1 = y1_r; end
      default: ;
    endcase
  end
  assign dot     = 33'(pa_r) + 33'(pb_r);
  assign diff_ab = 33'(pa_r) - 33'(pb_r);
  assign abs_ab  = diff_ab[32] ? -diff_ab : diff_ab;

  // divider and square root operands
  assign gs = $signed({1'b0, div_q[30:0]});
  always_comb begin
    tgt = '0;
    if (k_r == s1_r) tgt = t1_r;
    else if (k_r == s2_r) tgt = t2_r;
  end
  assign sdiff = 33'(tgt) - 33'(cur_q);
  assign smag  = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
  assign qmag  = div_q[32:0];
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DVS_W'(r_r);
    case (cmd.op)
      OP_G1_GO: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, m1_r, 30'b0} + DIV_W'(r_r[ROOT_W-1:1]);
      end
      OP_G2_GO: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, m2_r, 30'b0} + DIV_W'(r_r[ROOT_W-1:1]);
      end
      OP_ST_GO: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(smag);
        div_dvs   = DVS_W'(len);
      end
      default: ;
    endcase
  end
  assign sqrt_start = (cmd.op == OP_SQRT_GO);

  always_comb begin
    step_we = cmd.op == OP_ST_WAIT && div_done;
    if (!sneg_r) step_wd = (qmag > 33'h07fffffff) ? G_MAX : $signed(qmag[31:0]);
    else step_wd = (qmag > 33'h080000000) ? G_MIN : -$signed(qmag[31:0]);
  end

  always_comb begin
    csum   = 33'(cur_q) + 33'(step_q);
    cur_we = (cmd.op == OP_SM_UPD);
    if (csum > 33'sh07fffffff) cur_wd = G_MAX;
    else if (csum < -33'sh080000000) cur_wd = G_MIN;
    else cur_wd = csum[31:0];
  end

  assign rnd = 57'(prod_r) + 57'sd536870912;
  assign shv = rnd >>> 30;
  always_comb begin
    if (shv > 57'sd8388607) smp_sat = 24'sh7fffff;
    else if (shv < -57'sd8388608) smp_sat = -24'sd8388608;
    else smp_sat = shv[23:0];
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = cmd.op == OP_SM_EMIT && stat.k_emit && out_free;
  assign advance  = cmd.op == OP_SM_EMIT && (!stat.k_emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_go) begin
      out_r.channel    <= 4'(k_r);
      out_r.sample_out <= smp_sat;
      out_r.last       <= stat.k_last;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_data;
      k_r  <= '0;
    end
    case (cmd.op)
      OP_SC_MUL, OP_DET_MUL, OP_A1_MUL, OP_A2_MUL: begin
        pa_r <= ma0 * ma1;
        pb_r <= mb0 * mb1;
      end
      default: ;
    endcase
    case (cmd.op)
      OP_SC_CMP: begin
        if (k_r == '0) begin
          best1_r  <= dot;
          s1_r     <= '0;
          b2_vld_r <= 1'b0;
        end else if (dot > best1_r) begin
          best2_r  <= best1_r;
          s2_r     <= s1_r;
          b2_vld_r <= 1'b1;
          best1_r  <= dot;
          s1_r     <= k_r;
        end else if (!b2_vld_r || dot > best2_r) begin
          best2_r  <= dot;
          s2_r     <= k_r;
          b2_vld_r <= 1'b1;
        end
        k_r <= k_r + 1'b1;
      end
      OP_P2_RD: begin x1_r <= tx_rd_r; y1_r <= ty_rd_r; end
      OP_P_CAP: begin x2_r <= tx_rd_r; y2_r <= ty_rd_r; end
      OP_A1_MUL: begin detn_r <= diff_ab[32]; detnz_r <= (diff_ab != '0); end
      OP_A2_MUL: begin a1n_r <= diff_ab[32]; m1_r <= abs_ab[30:0]; end
      OP_A2_SUB: begin a2n_r <= diff_ab[32]; m2_r <= abs_ab[30:0]; end
      OP_CHK: begin t1_r <= '0; t2_r <= '0; k_r <= '0; end
      OP_NORM: begin
        if (!stat.big) begin
          m1_r <= {m1_r[29:0], 1'b0};
          m2_r <= {m2_r[29:0], 1'b0};
        end
      end
      OP_SQ1: sq1_r <= m1_r * m1_r;
      OP_SQ2: sq2_r <= m2_r * m2_r;
      OP_SQRT_WAIT: if (sqrt_done) r_r <= sqrt_root;
      OP_G1_WAIT: if (div_done) t1_r <= (a1n_r != detn_r) ? -gs : gs;
      OP_G2_WAIT: if (div_done) t2_r <= (a2n_r != detn_r) ? -gs : gs;
      OP_ST_GO: sneg_r <= sdiff[32];
      OP_ST_WAIT: if (div_done) k_r <= k_r + 1'b1;
      OP_SM_UPD: cnew_r <= cur_wd;
      OP_SM_MUL: prod_r <= cnew_r * in_r.sample_in;
      OP_SM_EMIT: if (advance) k_r <= k_r + 1'b1;
      default: ;
    endcase
  end

  vbap_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  vbap_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({1'b0, 63'(sq1_r) + 63'(sq2_r)}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/vbap_2d_panner_with_gain_ramp.sv -----
// Top level of the 2D VBAP panner with per-block gain ramps.
// Load word: written into the speaker table on accept. Sample word: for each table speaker in turn,
// read, update, multiply and emit states, the emit waiting on out_ready for active speakers.
// Direction word: speaker scan, base setup, normalize, two squares, sqrt and two gain divides,
// then a step divide per table speaker; degenerate base skips to the steps. No new word until done.
// Reset: speaker_count 2, block_length 64, all gains and steps zero; table undefined.
module vbap_2d_panner_with_gain_ramp
  import vbap_pkg::*;
#(
  parameter int MAX_SPEAKERS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vbap_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vbap_out_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  vbap_cmd_t  cmd;
  vbap_stat_t stat;

  vbap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vbap_dp #(
    .MAX_SPEAKERS (MAX_SPEAKERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
